// ----- hw/rtl/irdb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdb_pkg
// Shared types and constants of the IR duration bit decoder.
// ----------------------------------------------------------------------------
package irdb_pkg;

  localparam int unsigned CODE_BITS_DEFAULT = 32;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ENC_W   = 2;
  localparam int unsigned ADDR_W  = 2;
  localparam int unsigned CFG_W   = 16;

  // Register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_SHORT_LIMIT  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_SIGNAL_LIMIT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_ENCODING     = 2'd2;

  localparam logic [DUR_W-1:0] SHORT_LIMIT_RST  = 16'd800;
  localparam logic [DUR_W-1:0] SIGNAL_LIMIT_RST = 16'd4000;

  typedef enum logic [ENC_W-1:0] {
    ENC_PULSE = 2'd0,
    ENC_SPACE = 2'd1,
    ENC_SHIFT = 2'd2
  } enc_e;

  typedef struct packed {
    logic [DUR_W-1:0] short_limit;
    logic [DUR_W-1:0] signal_limit;
    logic [ENC_W-1:0] encoding;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bit_count;
    logic [CODE_W-1:0]  code;
  } result_t;

endpackage

// ----- hw/rtl/irdb_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdb_cfg_regs
// Configuration registers: short limit, signal limit and encoding.
// ----------------------------------------------------------------------------
module irdb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [irdb_pkg::ADDR_W-1:0]  cfg_addr_i,
  input  logic [irdb_pkg::CFG_W-1:0]   cfg_wdata_i,
  output irdb_pkg::cfg_t               cfg_o
);

  irdb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit  <= irdb_pkg::SHORT_LIMIT_RST;
      cfg_q.signal_limit <= irdb_pkg::SIGNAL_LIMIT_RST;
      cfg_q.encoding     <= irdb_pkg::ENC_PULSE;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        irdb_pkg::REG_SHORT_LIMIT:  cfg_q.short_limit  <= cfg_wdata_i;
        irdb_pkg::REG_SIGNAL_LIMIT: cfg_q.signal_limit <= cfg_wdata_i;
        irdb_pkg::REG_ENCODING:     cfg_q.encoding     <= cfg_wdata_i[irdb_pkg::ENC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/irdb_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdb_core
// Classify one duration beat and update the collected code word.
// ----------------------------------------------------------------------------
module irdb_core #(
  parameter int unsigned CODE_BITS = irdb_pkg::CODE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irdb_pkg::cfg_t               cfg_i,
  input  logic                         step_i,
  input  logic                         mode_i,
  input  logic                         is_mark_i,
  input  logic [irdb_pkg::DUR_W-1:0]   duration_us_i,
  output logic                         emit_o,
  output irdb_pkg::result_t            result_o
);

  logic [CODE_BITS-1:0]              shift_word_q, shift_word_d;
  logic [irdb_pkg::COUNT_W-1:0]      bits_seen_q, bits_seen_d;
  logic                              has_bits_q, has_bits_d;
  logic                              half_pending_q, half_pending_d;

  logic is_end, is_long, push, bit_val;

  assign is_end  = mode_i || (duration_us_i > cfg_i.signal_limit);
  assign is_long = duration_us_i > cfg_i.short_limit;
  assign emit_o  = is_end && has_bits_q;

  always_comb begin
    push           = 1'b0;
    bit_val        = is_long;
    half_pending_d = half_pending_q;
    case (cfg_i.encoding)
      irdb_pkg::ENC_PULSE: push = is_mark_i;
      irdb_pkg::ENC_SPACE: push = !is_mark_i;
      default: begin
        // biphase: a long item completes a pair by itself; a short one pairs up
        bit_val = is_mark_i;
        push    = is_long || half_pending_q;
        if (!is_long) begin
          half_pending_d = !half_pending_q;
        end
      end
    endcase
  end

  always_comb begin
    shift_word_d = shift_word_q;
    bits_seen_d  = bits_seen_q;
    has_bits_d   = has_bits_q;
    if (is_end) begin
      shift_word_d   = '0;
      bits_seen_d    = '0;
      has_bits_d     = 1'b0;
    end else if (push) begin
      shift_word_d = {shift_word_q[CODE_BITS-2:0], bit_val};
      if (bits_seen_q != '1) begin
        bits_seen_d = bits_seen_q + 1'b1;
      end
      has_bits_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_word_q   <= '0;
      bits_seen_q    <= '0;
      has_bits_q     <= 1'b0;
      half_pending_q <= 1'b0;
    end else if (step_i) begin
      shift_word_q   <= shift_word_d;
      bits_seen_q    <= bits_seen_d;
      has_bits_q     <= has_bits_d;
      half_pending_q <= is_end ? 1'b0 : half_pending_d;
    end
  end

  assign result_o.code      = irdb_pkg::CODE_W'(shift_word_q);
  assign result_o.bit_count = bits_seen_q;

endmodule

// ----- hw/rtl/irdb_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdb_out_reg
// Result register on the master side; hold the beat until taken.
// ----------------------------------------------------------------------------
module irdb_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  irdb_pkg::result_t  result_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output irdb_pkg::result_t  result_o
);

  logic              valid_q;
  irdb_pkg::result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/ir_duration_bit_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_duration_bit_decoder
// Turn IR mark/space durations into remote-control code words.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: duration_us[15:0]; tuser: mode[0], is_mark[1]
//  m_axis    out        tdata: code[31:0], bit_count[39:32]
//  cfg       in         write-only: short limit, signal limit, encoding
//
//  One beat per cycle while no result beat is blocked. A beat is decoded in
//  the input register and, if it ends a command with bits, lands in the result
//  register.
//  Reset clears the collected word, count and pending half-symbol, and loads
//  the limits 800 us / 4000 us with pulse-width encoding.
//  A stall on the master side holds a decoded beat only if it carries a result.
// ----------------------------------------------------------------------------
module ir_duration_bit_decoder #(
  parameter int unsigned CODE_BITS = irdb_pkg::CODE_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream: duration beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [irdb_pkg::DUR_W-1:0]         s_axis_tdata,  // duration_us[15:0]
  input  logic [1:0]                         s_axis_tuser,  // mode[0], is_mark[1]
  // master stream: code words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [irdb_pkg::CODE_W+irdb_pkg::COUNT_W-1:0] m_axis_tdata, // code[31:0], bit_count[39:32]
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [irdb_pkg::ADDR_W-1:0]        cfg_addr_i,
  input  logic [irdb_pkg::CFG_W-1:0]         cfg_wdata_i
);

  irdb_pkg::cfg_t    cfg;
  irdb_pkg::result_t result_w;
  irdb_pkg::result_t out_result;

  // input register
  logic                       in_valid_q;
  logic                       mode_q;
  logic                       is_mark_q;
  logic [irdb_pkg::DUR_W-1:0] duration_q;

  logic emit_w;
  logic out_free;
  logic advance;

  // A beat leaves the input register unless it has a result and the
  // result register is still full.
  assign advance       = in_valid_q && (!emit_w || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q     <= s_axis_tuser[0];
      is_mark_q  <= s_axis_tuser[1];
      duration_q <= s_axis_tdata;
    end
  end

  irdb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irdb_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (advance),
    .mode_i        (mode_q),
    .is_mark_i     (is_mark_q),
    .duration_us_i (duration_q),
    .emit_o        (emit_w),
    .result_o      (result_w)
  );

  irdb_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit_w),
    .result_i (result_w),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = out_result;

`ifndef ASSERT_OFF
  // an emitted command always shows up on the master side next cycle
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit_w |=> m_axis_tvalid)
    else $error("emitted result not presented");

  // the input register only stalls behind a blocked result beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // an emitted command never carries a zero bit count
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_w |-> result_w.bit_count != '0)
    else $error("emit with empty bit count");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IR duration bit decoder.
// Mark/space beats go in on the slave stream. A cycle-free decoder inside the
// bench tracks the collected word, count and pending half-symbol for every
// accepted beat. It queues each expected code word, and the monitor matches
// those against the master stream. Phases sweep the limits and all
// encodings, with random back-pressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import irdb_pkg::*;

  localparam int unsigned CODE_BITS    = CODE_BITS_DEFAULT;
  localparam int unsigned RESET_CYCLES = 6;
  // pipeline drain margin; lets a result-free beat leave the block
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned HOLD_PHASE   = 0;
  localparam int unsigned NO_GAP_PHASE = 2;
  localparam int unsigned SAT_PHASE    = 2;
  localparam int unsigned SAT_BITS     = 270;
  localparam int unsigned MAX_PRINTS   = 50;

  // index with no meaning in the block, and a spare encoding it decodes as shift
  localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [ENC_W-1:0]  ENC_SPARE  = 2'd3;

  localparam logic MODE_DURATION = 1'b0;
  localparam logic MODE_FLUSH    = 1'b1;
  localparam logic LVL_SPACE     = 1'b0;
  localparam logic LVL_MARK      = 1'b1;

  typedef enum int {DUR_SHORT, DUR_LONG, DUR_GAP} dur_kind_e;

  typedef struct packed {
    logic             mode;
    logic             is_mark;
    logic [DUR_W-1:0] duration;
  } pulse_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [DUR_W-1:0]          s_axis_tdata  = '0;  // duration_us[15:0]
  logic [1:0]                s_axis_tuser  = '0;  // mode[0], is_mark[1]
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [CODE_W+COUNT_W-1:0] m_axis_tdata;        // code[31:0], bit_count[39:32]
  logic                      cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0]         cfg_addr_i  = '0;
  logic [CFG_W-1:0]          cfg_wdata_i = '0;

  ir_duration_bit_decoder #(
    .CODE_BITS(CODE_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Decoder shadow: limits, encoding and collection state as the block holds
  // them. Reset values match the block's.
  // --------------------------------------------------------------------------
  logic [DUR_W-1:0]     exp_short_limit  = SHORT_LIMIT_RST;
  logic [DUR_W-1:0]     exp_signal_limit = SIGNAL_LIMIT_RST;
  logic [ENC_W-1:0]     exp_encoding     = ENC_PULSE;
  logic [CODE_BITS-1:0] rx_word          = '0;
  logic [COUNT_W-1:0]   rx_count         = '0;
  logic                 rx_has_bits      = 1'b0;
  logic                 rx_half          = 1'b0;

  result_t     expected_words[$];
  pulse_t      pending_pulses[$];
  pulse_t      offered;
  logic        drv_emit;
  result_t     drv_word;
  int unsigned items_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned src_gap_pct  = 25;
  int unsigned sink_gap_pct = 25;
  logic        hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  cfg_t        plan[NUM_PHASES];

  // Decode one accepted beat; return the code word it completes, if any.
  function automatic void decode_duration(input pulse_t p, output logic emit,
                                          output result_t word);
    logic is_long;
    logic take;
    logic bit_val;
    emit    = 1'b0;
    word    = '0;
    take    = 1'b0;
    bit_val = 1'b0;
    is_long = p.duration > exp_short_limit;
    if (p.mode == MODE_FLUSH || p.duration > exp_signal_limit) begin
      // header, gap or flush: close the command, drop any unpaired half
      if (rx_has_bits) begin
        emit           = 1'b1;
        word.code      = CODE_W'(rx_word);
        word.bit_count = rx_count;
      end
      rx_word     = '0;
      rx_count    = '0;
      rx_has_bits = 1'b0;
      rx_half     = 1'b0;
    end else begin
      case (exp_encoding)
        ENC_PULSE: begin
          take    = p.is_mark;
          bit_val = is_long;
        end
        ENC_SPACE: begin
          take    = !p.is_mark;
          bit_val = is_long;
        end
        default: begin
          // shift: a long item is a full pair by itself and leaves a pending
          // half untouched; a short one pairs up with the pending half
          bit_val = p.is_mark;
          if (is_long) begin
            take = 1'b1;
          end else if (rx_half) begin
            take    = 1'b1;
            rx_half = 1'b0;
          end else begin
            rx_half = 1'b1;
          end
        end
      endcase
      if (take) begin
        rx_word = {rx_word[CODE_BITS-2:0], bit_val};
        if (rx_count != '1) rx_count = rx_count + 1'b1;
        rx_has_bits = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word(input result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected code word %h count %0d",
                                got.code, got.bit_count));
      return;
    end
    want = expected_words.pop_front();
    if (got.code !== want.code)
      report_mismatch($sformatf("code %h, want %h", got.code, want.code));
    if (got.bit_count !== want.bit_count)
      report_mismatch($sformatf("bit_count %0d, want %0d",
                                got.bit_count, want.bit_count));
  endtask

  // --------------------------------------------------------------------------
  // Driver: predict on every accepted beat, then offer the next pending pulse
  // or idle at random. Advance only when the current beat is gone.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_duration(offered, drv_emit, drv_word);
        if (drv_emit) expected_words.push_back(drv_word);
        beats_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pulses.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          offered       = pending_pulses.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= offered.duration;
          s_axis_tuser  <= {offered.is_mark, offered.mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every accepted code word, stall at random, and honor a
  // long hold-off request by counting it down here.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word(result_t'(m_axis_tdata));
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req      = 1'b0;
        hold_left     = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic mode, input logic is_mark,
                          input logic [DUR_W-1:0] duration);
    pulse_t p;
    p.mode     = mode;
    p.is_mark  = is_mark;
    p.duration = duration;
    pending_pulses.push_back(p);
    items_queued++;
  endtask

  // Write one register while the block is idle; mirror it in the shadow.
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SHORT_LIMIT:  exp_short_limit  = val[DUR_W-1:0];
      REG_SIGNAL_LIMIT: exp_signal_limit = val[DUR_W-1:0];
      REG_ENCODING:     exp_encoding     = val[ENC_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued beat is in, every code word is out, and the
  // pipeline has emptied of result-free beats.
  task automatic finish_phase();
    while (beats_taken != items_queued) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Duration of a given kind under the current limits, often right at an edge.
  function automatic logic [DUR_W-1:0] dur_pick(input dur_kind_e kind);
    int lo;
    int hi;
    int s;
    int g;
    s = exp_short_limit;
    g = exp_signal_limit;
    lo = 0;
    hi = (s < g) ? s : g;
    if (kind == DUR_LONG && s < g) begin
      lo = s + 1;
      hi = g;
    end else if (kind == DUR_GAP) begin
      lo = (g < 65535) ? g + 1 : 0;
      hi = 65535;
    end
    case ($urandom_range(3))
      0:       return DUR_W'(lo);
      1:       return DUR_W'(hi);
      default: return DUR_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] data_dur();
    return dur_pick($urandom_range(1) ? DUR_LONG : DUR_SHORT);
  endfunction

  // Close a command with a gap, now and then with a flush; always a flush if no gap exists.
  task automatic end_command();
    if (exp_signal_limit != '1 && $urandom_range(4) != 0)
      add_item(MODE_DURATION, 1'($urandom_range(1)), dur_pick(DUR_GAP));
    else
      add_item(MODE_FLUSH, 1'($urandom_range(1)), DUR_W'($urandom_range(65535)));
  endtask

  task automatic add_frame(input int unsigned nbits);
    int unsigned k;
    logic lvl;
    if ($urandom_range(2) != 0) end_command();
    lvl = LVL_MARK;
    for (k = 0; k < nbits; k++) begin
      if (exp_encoding == ENC_PULSE || exp_encoding == ENC_SPACE) begin
        add_item(MODE_DURATION, LVL_MARK, data_dur());
        add_item(MODE_DURATION, LVL_SPACE, data_dur());
      end else begin
        // alternate levels as a real biphase line does
        add_item(MODE_DURATION, lvl, data_dur());
        lvl = !lvl;
      end
    end
    end_command();
  endtask

  task automatic add_noise();
    logic [DUR_W-1:0] d;
    if ($urandom_range(1))
      d = DUR_W'($urandom_range(65535));
    else
      d = dur_pick(dur_kind_e'($urandom_range(2)));
    add_item(($urandom_range(7) == 0) ? MODE_FLUSH : MODE_DURATION,
             1'($urandom_range(1)), d);
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned start;
    int unsigned r;
    start = items_queued;
    while (items_queued - start < count) begin
      r = $urandom_range(99);
      if (r < 15)      add_noise();
      else if (r < 22) add_frame(0);
      else if (r < 70) add_frame($urandom_range(12, 1));
      else             add_frame($urandom_range(40, 13));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned k;
    logic lvl;

    plan[0] = '{16'd800,   16'd4000,  ENC_PULSE};
    plan[1] = '{16'd560,   16'd1700,  ENC_SPACE};
    plan[2] = '{16'd889,   16'd2000,  ENC_SHIFT};
    plan[3] = '{16'd400,   16'd3000,  ENC_SPARE};
    plan[4] = '{16'd0,     16'd65535, ENC_PULSE};
    plan[5] = '{16'd65535, 16'd0,     ENC_SPACE};
    plan[6] = '{16'd65535, 16'd65535, ENC_SHIFT};
    plan[7] = '{16'd0,     16'd0,     ENC_SHIFT};
    plan[8] = '{16'd1000,  16'd60000, ENC_PULSE};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits, pulse-width: bits come from marks only
    add_item(MODE_FLUSH,    LVL_MARK,  16'hFFFF);  // flush with nothing collected
    add_item(MODE_DURATION, LVL_MARK,  16'd0);     // 0
    add_item(MODE_DURATION, LVL_SPACE, 16'd800);   // space carries nothing
    add_item(MODE_DURATION, LVL_MARK,  16'd801);   // 1, just long
    add_item(MODE_DURATION, LVL_MARK,  16'd4000);  // 1, longest data
    add_item(MODE_DURATION, LVL_SPACE, 16'd4001);  // gap: emit 3 bits
    add_item(MODE_DURATION, LVL_MARK,  16'hFFFF);  // gap with nothing collected
    add_item(MODE_DURATION, LVL_MARK,  16'd800);   // 0, longest short
    add_item(MODE_FLUSH,    LVL_SPACE, 16'd0);     // flush emits
    finish_phase();

    // Shift: short halves pair up, long items are whole pairs
    write_reg(REG_ENCODING, CFG_W'(ENC_SHIFT));
    add_item(MODE_DURATION, LVL_SPACE, 16'd100);
    add_item(MODE_DURATION, LVL_MARK,  16'd100);   // pair -> 1
    add_item(MODE_DURATION, LVL_MARK,  16'd2000);  // long -> 1
    add_item(MODE_DURATION, LVL_SPACE, 16'd300);   // unpaired half
    add_item(MODE_DURATION, LVL_MARK,  16'd5000);  // gap drops the half
    add_item(MODE_DURATION, LVL_SPACE, 16'd300);
    add_item(MODE_DURATION, LVL_SPACE, 16'd900);   // long keeps the half open
    add_item(MODE_DURATION, LVL_MARK,  16'd300);   // closes the half -> 1
    add_item(MODE_FLUSH,    LVL_MARK,  16'd0);
    finish_phase();

    // Space-width; the unused register index must change nothing
    write_reg(REG_ENCODING, CFG_W'(ENC_SPACE));
    write_reg(REG_UNUSED, '1);
    add_item(MODE_DURATION, LVL_SPACE, 16'd900);   // 1
    add_item(MODE_DURATION, LVL_MARK,  16'd900);   // mark carries nothing
    add_item(MODE_DURATION, LVL_SPACE, 16'd0);     // 0
    add_item(MODE_FLUSH,    LVL_MARK,  16'd65535);
    finish_phase();

    for (k = 0; k < NUM_PHASES; k++) begin
      write_reg(REG_SHORT_LIMIT,  plan[k].short_limit);
      write_reg(REG_SIGNAL_LIMIT, plan[k].signal_limit);
      write_reg(REG_ENCODING,     CFG_W'(plan[k].encoding));
      if (k == NO_GAP_PHASE) begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
      fill_random(RANDOM_ITEMS / NUM_PHASES);
      if (k == SAT_PHASE) begin
        // one word long enough to saturate the count and drop old bits
        end_command();
        lvl = LVL_MARK;
        for (int unsigned b = 0; b < SAT_BITS; b++) begin
          add_item(MODE_DURATION, lvl, dur_pick(DUR_LONG));
          lvl = !lvl;
        end
        end_command();
      end
      // hold the receiver while the sender keeps offering beats
      if (k == HOLD_PHASE) hold_req = 1'b1;
      finish_phase();
      src_gap_pct  = 25;
      sink_gap_pct = 25;
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
